[rtl/core/dd_pkg.sv]
// Shared types, status codes and calendar tables for the date difference core.
// No dependencies; every other file in rtl/core refers to this package by scoped names.

package dd_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FIRST_BAD  = 2'd1,
    STATUS_SECOND_BAD = 2'd2
  } status_t;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 23;

  // Quarter-year values (year >> 2) and their quotient by 25.
  localparam int unsigned QUART_W = YEAR_W - 2;
  localparam int unsigned Q25_W   = 8;

  // Reciprocal of 25 scaled by 2^17; exact for every 12-bit dividend.
  localparam int unsigned DIV25_SHIFT = 17;
  localparam int unsigned DIV25_W     = QUART_W + DIV25_SHIFT - 4;
  localparam logic [12:0] DIV25_MULT  = 13'd5243;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   LEAP_FEB_LEN = 5'd29;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    date_t first;
    date_t second;
  } date_pair_t;

  // Per-date result handed from the date evaluators to the compare stage.
  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] day_num;
  } date_info_t;

  // Days in each month of a common year; months outside 1..12 give zero.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                         len = 5'd28;
      default:                                      len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of each month in a common year.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
    logic [8:0] days;
    unique case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  // Floor division of a 12-bit value by 25 through a reciprocal multiply.
  function automatic logic [Q25_W-1:0] div25(input logic [QUART_W-1:0] q);
    logic [QUART_W+12:0] prod;
    prod = (QUART_W + 13)'(q) * (QUART_W + 13)'(DIV25_MULT);
    return prod[DIV25_SHIFT +: Q25_W];
  endfunction

endpackage

[rtl/core/dd_if.sv]
// Handshake channels of the date difference core: one for date pairs, one for results.
// Depends on dd_pkg for field widths.

interface dd_in_if;
  logic                            valid;
  logic                            ready;
  logic [dd_pkg::DAY_W-1:0]        first_day;
  logic [dd_pkg::MONTH_W-1:0]      first_month;
  logic [dd_pkg::YEAR_W-1:0]       first_year;
  logic [dd_pkg::DAY_W-1:0]        second_day;
  logic [dd_pkg::MONTH_W-1:0]      second_month;
  logic [dd_pkg::YEAR_W-1:0]       second_year;

  modport source (
    output valid, first_day, first_month, first_year, second_day, second_month, second_year,
    input  ready
  );
  modport sink (
    input  valid, first_day, first_month, first_year, second_day, second_month, second_year,
    output ready
  );
endinterface

interface dd_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [dd_pkg::COUNT_W-1:0]      day_count;

  modport source (output valid, status, day_count, input ready);
  modport sink   (input valid, status, day_count, output ready);
endinterface

[rtl/core/date_difference_days_core.sv]
// Absolute number of days between two proleptic Gregorian dates, with a check of both dates.
// One date pair is taken per clock while the output is drained: the pair lands in an input
// register, both dates are evaluated side by side, and the status and count are captured in
// a result register that drives the output. A word that waits at the output stalls the input
// only once the input register is also full, so the sustained rate is one word per cycle
// while the output is drained.
// Status 0 means both dates are valid, 1 that the first is invalid (the second is not
// examined), 2 that the second is invalid; the count is zero whenever the status is not 0.
// A year is valid from 1 up to MAX_YEAR. Depends on dd_pkg, dd_if, dd_date_eval and dd_compare.

module date_difference_days_core #(
  parameter int unsigned MAX_YEAR = 16383
) (
  input  logic           clk,
  input  logic           rst,
  dd_in_if.sink          dates,
  dd_out_if.source       result
);

  logic                         s1_valid;
  dd_pkg::date_pair_t           s1_dates;
  logic                         s1_advance;
  dd_pkg::date_info_t           first_info;
  dd_pkg::date_info_t           second_info;
  dd_pkg::status_t              status_next;
  logic [dd_pkg::COUNT_W-1:0]   day_count_next;
  logic                         out_valid;
  dd_pkg::status_t              out_status;
  logic [dd_pkg::COUNT_W-1:0]   out_day_count;

  // The input register moves on whenever the result register is empty or being drained.
  assign s1_advance  = !out_valid || result.ready;
  assign dates.ready = !s1_valid || s1_advance;

  // Control registers of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (dates.ready) begin
        s1_valid <= dates.valid;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (dates.valid && dates.ready) begin
      s1_dates.first.day     <= dates.first_day;
      s1_dates.first.month   <= dates.first_month;
      s1_dates.first.year    <= dates.first_year;
      s1_dates.second.day    <= dates.second_day;
      s1_dates.second.month  <= dates.second_month;
      s1_dates.second.year   <= dates.second_year;
    end
  end

  // Both dates are evaluated in parallel.
  dd_date_eval #(.MAX_YEAR(MAX_YEAR)) u_first_eval (
    .date (s1_dates.first),
    .info (first_info)
  );

  dd_date_eval #(.MAX_YEAR(MAX_YEAR)) u_second_eval (
    .date (s1_dates.second),
    .info (second_info)
  );

  dd_compare u_compare (
    .first     (first_info),
    .second    (second_info),
    .status    (status_next),
    .day_count (day_count_next)
  );

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      out_status    <= status_next;
      out_day_count <= day_count_next;
    end
  end

  assign result.valid     = out_valid;
  assign result.status    = out_status;
  assign result.day_count = out_day_count;

  // A word in the input register with room downstream reaches the output next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_advance |=> result.valid)
    else $error("input register word did not reach the result register");

  // An invalid date never carries a nonzero count.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status != dd_pkg::STATUS_OK) |-> (result.day_count == '0))
    else $error("nonzero day count with a failing status");

  // An empty input register always takes a new word.
  assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> dates.ready)
    else $error("input stalled while the input register is empty");

  // Reset empties both stages.
  assert property (@(posedge clk)
    rst |=> !s1_valid && !result.valid)
    else $error("pipeline not empty after reset");

endmodule

[rtl/core/dd_date_eval.sv]
// Validity check and day number of one Gregorian date, purely combinational.
// Depends on dd_pkg for the date types, month tables and the divide-by-25 helper.

module dd_date_eval #(
  parameter int unsigned MAX_YEAR = 16383
) (
  input  dd_pkg::date_t      date,
  output dd_pkg::date_info_t info
);

  localparam int unsigned YEXT_W = 17;
  localparam logic [YEXT_W-1:0] YEAR_LIMIT = YEXT_W'(MAX_YEAR);

  logic                          year_ok;
  logic                          month_ok;
  logic                          day_ok;
  logic                          leap;
  logic [dd_pkg::QUART_W-1:0]    y_quart;
  logic [dd_pkg::Q25_W-1:0]      y_q25;
  logic                          y_quart_mult25;
  logic [dd_pkg::DAY_W-1:0]      day_limit;
  logic [dd_pkg::YEAR_W-1:0]     prev_year;
  logic [dd_pkg::QUART_W-1:0]    p_quart;
  logic [dd_pkg::Q25_W-1:0]      p_cent;
  logic [dd_pkg::COUNT_W-1:0]    year_days;
  logic [dd_pkg::COUNT_W-1:0]    month_days;

  // Leap year: divisible by 4, and not a century unless divisible by 400.
  // With q = year/4, a century means q is a multiple of 25; a 400th year also has q/25 even by 4.
  always_comb begin
    y_quart        = date.year[dd_pkg::YEAR_W-1:2];
    y_q25          = dd_pkg::div25(y_quart);
    y_quart_mult25 = (y_quart == (dd_pkg::QUART_W'(y_q25) * dd_pkg::QUART_W'(25)));
    leap           = (date.year[1:0] == 2'b00) && (!y_quart_mult25 || (y_q25[1:0] == 2'b00));
  end

  // Field range checks.
  always_comb begin
    year_ok  = (date.year != '0) && (YEXT_W'(date.year) <= YEAR_LIMIT);
    month_ok = (date.month >= dd_pkg::MONTH_JAN) && (date.month <= dd_pkg::MONTH_DEC);
    day_limit = dd_pkg::month_len(date.month);
    if (date.month == dd_pkg::MONTH_FEB && leap) begin
      day_limit = dd_pkg::LEAP_FEB_LEN;
    end
    day_ok = (date.day != '0) && (date.day <= day_limit);
  end

  // Day number counted from 1 January of year 1 as day 1.
  // Centuries come from (year-1)/4/25 and 400-year periods from that quotient over 4.
  always_comb begin
    prev_year  = date.year - dd_pkg::YEAR_W'(1);
    p_quart    = prev_year[dd_pkg::YEAR_W-1:2];
    p_cent     = dd_pkg::div25(p_quart);
    year_days  = dd_pkg::COUNT_W'(prev_year) * dd_pkg::COUNT_W'(365)
               + dd_pkg::COUNT_W'(p_quart)
               - dd_pkg::COUNT_W'(p_cent)
               + dd_pkg::COUNT_W'(p_cent[dd_pkg::Q25_W-1:2]);
    month_days = dd_pkg::COUNT_W'(dd_pkg::days_before(date.month))
               + dd_pkg::COUNT_W'((date.month > dd_pkg::MONTH_FEB) && leap)
               + dd_pkg::COUNT_W'(date.day);
  end

  assign info.ok      = year_ok && month_ok && day_ok;
  assign info.day_num = year_days + month_days;

endmodule

[rtl/core/dd_compare.sv]
// Picks the status of a date pair and forms the absolute day difference.
// Depends on dd_pkg for the per-date info struct and the status codes.

module dd_compare (
  input  dd_pkg::date_info_t         first,
  input  dd_pkg::date_info_t         second,
  output dd_pkg::status_t            status,
  output logic [dd_pkg::COUNT_W-1:0] day_count
);

  logic first_later;

  // The first date is checked before the second; a bad date gives a zero count.
  always_comb begin
    first_later = (first.day_num >= second.day_num);
    priority if (!first.ok) begin
      status    = dd_pkg::STATUS_FIRST_BAD;
      day_count = '0;
    end else if (!second.ok) begin
      status    = dd_pkg::STATUS_SECOND_BAD;
      day_count = '0;
    end else begin
      status    = dd_pkg::STATUS_OK;
      day_count = first_later ? (first.day_num - second.day_num)
                              : (second.day_num - first.day_num);
    end
  end

endmodule
